@@ hdl/ystep_pkg.sv @@
// Shared types, codes and helper functions of the Y86-64 instruction step engine.
`default_nettype none
package ystep_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_HALT  = 3'd1;
  localparam logic [2:0] ST_INV   = 3'd2;
  localparam logic [2:0] ST_SHORT = 3'd3;
  localparam logic [2:0] ST_ADR   = 3'd4;
  localparam logic [2:0] ST_DIVZ  = 3'd5;

  // Instruction codes.
  localparam logic [3:0] I_HALT  = 4'h0;
  localparam logic [3:0] I_NOP   = 4'h1;
  localparam logic [3:0] I_CMOV  = 4'h2;
  localparam logic [3:0] I_IRMOV = 4'h3;
  localparam logic [3:0] I_RMMOV = 4'h4;
  localparam logic [3:0] I_MRMOV = 4'h5;
  localparam logic [3:0] I_OPQ   = 4'h6;
  localparam logic [3:0] I_JXX   = 4'h7;
  localparam logic [3:0] I_CALL  = 4'h8;
  localparam logic [3:0] I_RET   = 4'h9;
  localparam logic [3:0] I_PUSH  = 4'hA;
  localparam logic [3:0] I_POP   = 4'hB;

  // ALU function codes.
  localparam logic [3:0] F_ADD = 4'h0;
  localparam logic [3:0] F_SUB = 4'h1;
  localparam logic [3:0] F_AND = 4'h2;
  localparam logic [3:0] F_XOR = 4'h3;
  localparam logic [3:0] F_MUL = 4'h4;
  localparam logic [3:0] F_DIV = 4'h5;
  localparam logic [3:0] F_MOD = 4'h6;

  localparam logic [3:0] RNONE = 4'hF;
  localparam logic [3:0] RSP   = 4'h4;
  localparam int         NREG  = 15;

  typedef enum logic {K_LOAD, K_STEP} kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DEC0, S_DEC1, S_REGA, S_REGB, S_EXEC,
    S_MUL, S_DIV, S_ALUW, S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

  // True when eight bytes starting at a lie fully below the limit l.
  function automatic logic quad_ok(input logic [63:0] a, input logic [63:0] l);
    quad_ok = (l >= 64'd8) && (a <= l - 64'd8);
  endfunction

  // Branch and move condition from the zero and sign flags.
  function automatic logic cond_ok(input logic [3:0] f, input logic zf, input logic sf);
    case (f)
      4'd0: cond_ok = 1'b1;
      4'd1: cond_ok = zf | sf;
      4'd2: cond_ok = sf;
      4'd3: cond_ok = zf;
      4'd4: cond_ok = ~zf;
      4'd5: cond_ok = ~sf;
      default: cond_ok = ~zf & ~sf;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/ystep_if.sv @@
// Handshake channel interfaces for input items and result items.
`default_nettype none
interface ystep_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [11:0] load_address;
  logic [7:0]  load_data;
  modport source(output valid, command, load_address, load_data, input ready);
  modport sink(input valid, command, load_address, load_data, output ready);
endinterface

interface ystep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] pc;
  logic        flag_zero;
  logic        flag_sign;
  logic        reg_written;
  logic [3:0]  reg_index;
  logic [63:0] reg_value;
  logic [63:0] stack_pointer;
  logic        mem_written;
  logic [11:0] mem_address;
  logic [63:0] mem_value;
  modport source(output valid, status, pc, flag_zero, flag_sign, reg_written, reg_index,
                 reg_value, stack_pointer, mem_written, mem_address, mem_value,
                 input ready);
  modport sink(input valid, status, pc, flag_zero, flag_sign, reg_written, reg_index,
               reg_value, stack_pointer, mem_written, mem_address, mem_value,
               output ready);
endinterface
`default_nettype wire

@@ hdl/ystep_div.sv @@
// Iterative unsigned 64-bit divider, one quotient bit per cycle.
`default_nettype none
module ystep_div
  import ystep_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [63:0] quo;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem, quo[63]} - {1'b0, dvs};

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
      end else begin
        rem <= {rem[62:0], quo[63]};
      end
      quo <= {quo[62:0], ~trial[64]};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

@@ hdl/ystep_front.sv @@
// Front end: accepts input beats, classifies them and queues them for the back end.
`default_nettype none
module ystep_front
  import ystep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ystep_in_if.sink    req,
  output item_t       q_item,
  output logic        q_valid,
  input  logic        q_ready
);

  item_t      entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  item_t      item_in;

  // Classify the incoming beat.
  always_comb begin
    item_in.kind = req.command ? K_STEP : K_LOAD;
    item_in.addr = req.load_address;
    item_in.data = req.load_data;
  end

  assign req.ready = (cnt != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (cnt != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = entries[rp];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) entries[wp] <= item_in;
  end

endmodule
`default_nettype wire

@@ hdl/ystep_back.sv @@
// Back end: byte memory, register file and the sequencer that carries out each item.
`default_nettype none
module ystep_back
  import ystep_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  item_t       q_item,
  input  logic        q_valid,
  output logic        q_ready,
  ystep_out_if.source rsp
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int LIMW = (AW + 1 > 13) ? AW + 1 : 13;

  state_t state, state_next;

  // Architectural state.
  logic [12:0] mem_limit;
  logic [63:0] rf [NREG];
  logic [63:0] pc;
  logic        fz;
  logic        fs;
  logic [7:0]  mem [MEM_BYTES];

  // Working registers.
  logic [63:0] rd_addr;
  logic [3:0]  rd_cnt;
  logic [3:0]  rd_len;
  logic        rd_pend;
  state_t      rd_ret;
  logic [63:0] acc;
  logic [3:0]  ic;
  logic [3:0]  fn;
  logic [3:0]  ra;
  logic [3:0]  rb;
  logic [63:0] va;
  logic [63:0] vb;
  logic [63:0] alu_r;
  logic [31:0] mpart;
  logic [1:0]  mcnt;
  logic [63:0] waddr;
  logic [63:0] wdat;
  logic [2:0]  wcnt;
  logic        phase;
  logic [2:0]  res_status;
  logic        res_rw;
  logic [3:0]  res_ri;
  logic [63:0] res_rv;
  logic        res_mw;
  logic [11:0] res_ma;
  logic [63:0] res_mv;

  // Memory port signals.
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic [7:0]    mem_q;

  // Sequencer decisions.
  logic        fin;
  logic [2:0]  fin_st;
  logic        rd_go;
  logic [63:0] rd_a;
  logic [3:0]  rd_l;
  state_t      rd_r;

  logic [LIMW-1:0] lim;
  logic [63:0]     lim64;
  logic [63:0]     sp;
  logic [63:0]     spm8;
  logic [63:0]     ea;
  logic [7:0]      b0;
  logic [3:0]      b0_hi;
  logic [3:0]      b0_lo;

  div_req_t dreq;
  div_rsp_t drsp;

  ystep_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // Usable limit and common addresses.
  always_comb begin
    lim   = (LIMW'(mem_limit) < LIMW'(MEM_BYTES)) ? LIMW'(mem_limit) : LIMW'(MEM_BYTES);
    lim64 = 64'(lim);
    sp    = rf[RSP];
    spm8  = sp - 64'd8;
    ea    = vb + acc;
    b0    = acc[63:56];
    b0_hi = b0[7:4];
    b0_lo = b0[3:0];
  end

  // Divider request.
  always_comb begin
    dreq.start    = (state == S_EXEC) && (ic == I_OPQ) && (fn == F_DIV || fn == F_MOD) &&
                    (va != 64'd0);
    dreq.dividend = vb;
    dreq.divisor  = va;
  end

  // Next state and sequencing decisions.
  always_comb begin
    state_next = state;
    fin        = 1'b0;
    fin_st     = ST_OK;
    rd_go      = 1'b0;
    rd_a       = pc;
    rd_l       = 4'd1;
    rd_r       = S_IDLE;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.kind == K_LOAD) begin
            fin    = 1'b1;
            fin_st = (64'(q_item.addr) < lim64) ? ST_OK : ST_ADR;
          end else if (pc >= lim64) begin
            fin    = 1'b1;
            fin_st = ST_SHORT;
          end else begin
            rd_go = 1'b1;
            rd_a  = pc;
            rd_l  = 4'd1;
            rd_r  = S_DEC0;
          end
        end
      end
      S_READ: begin
        if (rd_pend && rd_cnt == rd_len) state_next = rd_ret;
      end
      S_DEC0: begin
        case (b0_hi)
          I_HALT, I_NOP, I_RET: begin
            fin = 1'b1;
            if (b0_lo != 4'd0) fin_st = ST_INV;
            else if (b0_hi == I_HALT) fin_st = ST_HALT;
            else if (b0_hi == I_NOP) fin_st = ST_OK;
            else if (!quad_ok(sp, lim64)) fin_st = ST_ADR;
            else begin
              fin   = 1'b0;
              rd_go = 1'b1;
              rd_a  = sp;
              rd_l  = 4'd8;
              rd_r  = S_EXEC;
            end
          end
          I_JXX, I_CALL: begin
            if ((b0_hi == I_JXX) ? (b0_lo > F_MOD) : (b0_lo != 4'd0)) begin
              fin    = 1'b1;
              fin_st = ST_INV;
            end else if (!quad_ok(pc + 64'd1, lim64)) begin
              fin    = 1'b1;
              fin_st = ST_SHORT;
            end else begin
              rd_go = 1'b1;
              rd_a  = pc + 64'd1;
              rd_l  = 4'd8;
              rd_r  = S_EXEC;
            end
          end
          I_CMOV, I_IRMOV, I_RMMOV, I_MRMOV, I_OPQ, I_PUSH, I_POP: begin
            if (pc + 64'd1 >= lim64) begin
              fin    = 1'b1;
              fin_st = ST_SHORT;
            end else begin
              rd_go = 1'b1;
              rd_a  = pc + 64'd1;
              rd_l  = 4'd1;
              rd_r  = S_DEC1;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = ST_INV;
          end
        endcase
      end
      S_DEC1: begin
        // Register byte is in b0; icode and ifun are latched.
        case (ic)
          I_CMOV, I_OPQ: begin
            if (fn > F_MOD || b0_hi == RNONE || b0_lo == RNONE) begin
              fin    = 1'b1;
              fin_st = ST_INV;
            end else begin
              state_next = S_REGA;
            end
          end
          I_IRMOV, I_RMMOV, I_MRMOV: begin
            if (fn != 4'd0 || b0_lo == RNONE ||
                ((ic == I_IRMOV) ? (b0_hi != RNONE) : (b0_hi == RNONE))) begin
              fin    = 1'b1;
              fin_st = ST_INV;
            end else if (!quad_ok(pc + 64'd2, lim64)) begin
              fin    = 1'b1;
              fin_st = ST_SHORT;
            end else if (ic == I_IRMOV) begin
              rd_go = 1'b1;
              rd_a  = pc + 64'd2;
              rd_l  = 4'd8;
              rd_r  = S_EXEC;
            end else begin
              state_next = S_REGA;
            end
          end
          I_PUSH, I_POP: begin
            if (fn != 4'd0 || b0_hi == RNONE || b0_lo != RNONE) begin
              fin    = 1'b1;
              fin_st = ST_INV;
            end else if (ic == I_PUSH) begin
              state_next = S_REGA;
            end else if (!quad_ok(sp, lim64)) begin
              fin    = 1'b1;
              fin_st = ST_ADR;
            end else begin
              rd_go = 1'b1;
              rd_a  = sp;
              rd_l  = 4'd8;
              rd_r  = S_EXEC;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = ST_INV;
          end
        endcase
      end
      S_REGA: begin
        state_next = (ic == I_CMOV || ic == I_PUSH) ? S_EXEC : S_REGB;
      end
      S_REGB: begin
        if (ic == I_RMMOV || ic == I_MRMOV) begin
          rd_go = 1'b1;
          rd_a  = pc + 64'd2;
          rd_l  = 4'd8;
          rd_r  = S_EXEC;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (ic)
          I_CALL, I_PUSH: begin
            if (!quad_ok(spm8, lim64)) begin
              fin    = 1'b1;
              fin_st = ST_ADR;
            end else begin
              state_next = S_WRITE;
            end
          end
          I_RMMOV: begin
            if (!quad_ok(ea, lim64)) begin
              fin    = 1'b1;
              fin_st = ST_ADR;
            end else begin
              state_next = S_WRITE;
            end
          end
          I_MRMOV: begin
            if (phase) begin
              fin = 1'b1;
            end else if (!quad_ok(ea, lim64)) begin
              fin    = 1'b1;
              fin_st = ST_ADR;
            end else begin
              rd_go = 1'b1;
              rd_a  = ea;
              rd_l  = 4'd8;
              rd_r  = S_EXEC;
            end
          end
          I_OPQ: begin
            if ((fn == F_DIV || fn == F_MOD) && va == 64'd0) begin
              fin    = 1'b1;
              fin_st = ST_DIVZ;
            end else if (fn == F_MUL) begin
              state_next = S_MUL;
            end else if (fn == F_DIV || fn == F_MOD) begin
              state_next = S_DIV;
            end else begin
              state_next = S_ALUW;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      S_MUL: begin
        if (mcnt == 2'd3) state_next = S_ALUW;
      end
      S_DIV: begin
        if (drsp.done) state_next = S_ALUW;
      end
      S_ALUW: fin = 1'b1;
      S_WRITE: begin
        if (wcnt == 3'd7) fin = 1'b1;
      end
      S_DONE: begin
        if (rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (fin) state_next = S_DONE;
    if (rd_go) state_next = S_READ;
  end

  // Handshake and memory port controls.
  always_comb begin
    q_ready = (state == S_IDLE);
    mem_we  = 1'b0;
    mem_wa  = AW'(waddr);
    mem_wd  = wdat[7:0];
    if (state == S_WRITE) begin
      mem_we = 1'b1;
    end else if (state == S_IDLE && q_valid && q_item.kind == K_LOAD &&
                 64'(q_item.addr) < lim64) begin
      mem_we = 1'b1;
      mem_wa = AW'(q_item.addr);
      mem_wd = q_item.data;
    end
  end

  // Byte memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_q <= mem[AW'(rd_addr)];
  end

  // Sequencer state, configuration and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mem_limit <= 13'd4096;
      pc        <= '0;
      fz        <= 1'b0;
      fs        <= 1'b0;
      for (int i = 0; i < NREG; i++) rf[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) mem_limit <= cfg_wdata;
      case (state)
        S_DEC0: begin
          if (b0_hi == I_NOP && b0_lo == 4'd0) pc <= pc + 64'd1;
        end
        S_EXEC: begin
          case (ic)
            I_RET: begin
              pc      <= acc;
              rf[RSP] <= sp + 64'd8;
            end
            I_JXX: pc <= cond_ok(fn, fz, fs) ? acc : pc + 64'd9;
            I_CALL: begin
              if (quad_ok(spm8, lim64)) begin
                rf[RSP] <= spm8;
                pc      <= acc;
              end
            end
            I_IRMOV: begin
              rf[rb] <= acc;
              pc     <= pc + 64'd10;
            end
            I_RMMOV: begin
              if (quad_ok(ea, lim64)) pc <= pc + 64'd10;
            end
            I_MRMOV: begin
              if (phase) begin
                rf[ra] <= acc;
                pc     <= pc + 64'd10;
              end
            end
            I_CMOV: begin
              if (cond_ok(fn, fz, fs)) rf[rb] <= va;
              pc <= pc + 64'd2;
            end
            I_PUSH: begin
              if (quad_ok(spm8, lim64)) begin
                rf[RSP] <= spm8;
                pc      <= pc + 64'd2;
              end
            end
            I_POP: begin
              // A pop into the stack pointer keeps the popped value.
              rf[RSP] <= sp + 64'd8;
              rf[ra]  <= acc;
              pc      <= pc + 64'd2;
            end
            default: ;
          endcase
        end
        S_ALUW: begin
          rf[rb] <= alu_r;
          fz     <= (alu_r == 64'd0);
          fs     <= alu_r[63];
          pc     <= pc + 64'd2;
        end
        default: ;
      endcase
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (rd_go) begin
      rd_addr <= rd_a;
      rd_len  <= rd_l;
      rd_cnt  <= '0;
      rd_pend <= 1'b0;
      rd_ret  <= rd_r;
    end
    if (fin) res_status <= fin_st;
    case (state)
      S_IDLE: begin
        res_rw <= 1'b0;
        res_ri <= '0;
        res_rv <= '0;
        res_mw <= 1'b0;
        res_ma <= '0;
        res_mv <= '0;
        phase  <= 1'b0;
      end
      S_READ: begin
        // Issue one byte a cycle; the registered read data is shifted into acc.
        if (rd_cnt < rd_len) begin
          rd_addr <= rd_addr + 64'd1;
          rd_cnt  <= rd_cnt + 4'd1;
          rd_pend <= 1'b1;
        end else begin
          rd_pend <= 1'b0;
        end
        if (rd_pend) acc <= {mem_q, acc[63:8]};
      end
      S_DEC0: begin
        ic <= b0_hi;
        fn <= b0_lo;
      end
      S_DEC1: begin
        ra <= b0_hi;
        rb <= b0_lo;
      end
      S_REGA: va <= rf[ra];
      S_REGB: vb <= rf[rb];
      S_EXEC: begin
        wcnt <= '0;
        mcnt <= '0;
        case (ic)
          I_CALL: begin
            waddr  <= spm8;
            wdat   <= pc + 64'd9;
            res_mw <= 1'b1;
            res_ma <= spm8[11:0];
            res_mv <= pc + 64'd9;
          end
          I_PUSH: begin
            waddr  <= spm8;
            wdat   <= va;
            res_mw <= 1'b1;
            res_ma <= spm8[11:0];
            res_mv <= va;
          end
          I_RMMOV: begin
            waddr  <= ea;
            wdat   <= va;
            res_mw <= 1'b1;
            res_ma <= ea[11:0];
            res_mv <= va;
          end
          I_IRMOV: begin
            res_rw <= 1'b1;
            res_ri <= rb;
            res_rv <= acc;
          end
          I_MRMOV: begin
            if (phase) begin
              res_rw <= 1'b1;
              res_ri <= ra;
              res_rv <= acc;
            end else begin
              phase <= 1'b1;
            end
          end
          I_CMOV: begin
            if (cond_ok(fn, fz, fs)) begin
              res_rw <= 1'b1;
              res_ri <= rb;
              res_rv <= va;
            end
          end
          I_POP: begin
            res_rw <= 1'b1;
            res_ri <= ra;
            res_rv <= acc;
          end
          I_OPQ: begin
            case (fn)
              F_ADD:   alu_r <= vb + va;
              F_SUB:   alu_r <= vb - va;
              F_AND:   alu_r <= vb & va;
              F_XOR:   alu_r <= vb ^ va;
              default: alu_r <= '0;
            endcase
          end
          default: ;
        endcase
        // A failed store check leaves no store in the result.
        if ((ic == I_CALL || ic == I_PUSH) && !quad_ok(spm8, lim64)) res_mw <= 1'b0;
        if (ic == I_RMMOV && !quad_ok(ea, lim64)) res_mw <= 1'b0;
        if ((ic == I_CALL || ic == I_PUSH) && !quad_ok(spm8, lim64)) res_ma <= '0;
        if ((ic == I_CALL || ic == I_PUSH) && !quad_ok(spm8, lim64)) res_mv <= '0;
        if (ic == I_RMMOV && !quad_ok(ea, lim64)) res_ma <= '0;
        if (ic == I_RMMOV && !quad_ok(ea, lim64)) res_mv <= '0;
      end
      S_MUL: begin
        // Low 64 bits of the product from three 32x32 partial products.
        mcnt <= mcnt + 2'd1;
        case (mcnt)
          2'd0: alu_r <= 64'(vb[31:0]) * 64'(va[31:0]);
          2'd1: mpart <= vb[31:0] * va[63:32];
          2'd2: begin
            mpart         <= vb[63:32] * va[31:0];
            alu_r[63:32] <= alu_r[63:32] + mpart;
          end
          default: alu_r[63:32] <= alu_r[63:32] + mpart;
        endcase
      end
      S_DIV: begin
        if (drsp.done) alu_r <= (fn == F_DIV) ? drsp.quo : drsp.rem;
      end
      S_ALUW: begin
        res_rw <= 1'b1;
        res_ri <= rb;
        res_rv <= alu_r;
      end
      S_WRITE: begin
        wcnt  <= wcnt + 3'd1;
        waddr <= waddr + 64'd1;
        wdat  <= {8'd0, wdat[63:8]};
      end
      default: ;
    endcase
  end

  // Result channel.
  always_comb begin
    rsp.valid         = (state == S_DONE);
    rsp.status        = res_status;
    rsp.pc            = pc;
    rsp.flag_zero     = fz;
    rsp.flag_sign     = fs;
    rsp.reg_written   = res_rw;
    rsp.reg_index     = res_ri;
    rsp.reg_value     = res_rv;
    rsp.stack_pointer = sp;
    rsp.mem_written   = res_mw;
    rsp.mem_address   = res_ma;
    rsp.mem_value     = res_mv;
  end

endmodule
`default_nettype wire

@@ hdl/y86_instruction_step_engine.sv @@
// Top level of the Y86-64 instruction step engine.
// Each input beat either loads one byte into program memory (command 0) or executes one
// instruction (command 1), and yields exactly one result beat. A front queue of two beats
// takes input while the back end works or while a result waits. Items are carried out
// one at a time by a sequencer around a byte memory with one write port and one registered
// read port that returns one byte per cycle. Divide and modulo use the bit-serial divider.
// memory_limit is written through cfg_we/cfg_wdata; the user must do so only while no item
// is in flight, since the block itself does not enforce this.
`default_nettype none
module y86_instruction_step_engine
  import ystep_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  ystep_in_if.sink    req,
  ystep_out_if.source rsp
);

  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  ystep_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  ystep_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
